>>> src/ptse_pkg.sv
// Shared types and constants for the PDF text string extractor.
// Holds the transaction structs, parser mode codes and character codes.
// Used by every module of the block; has no dependencies.
package ptse_pkg;

	// Limits on captured text
	localparam int MAX_STRINGS = 256;
	localparam int MAX_TEXT    = 1024;
	localparam int TLEN_W      = $clog2(MAX_TEXT + 1);
	localparam int SCNT_W      = $clog2(MAX_STRINGS + 1);
	localparam logic [7:0] DEPTH_MAX = 8'd255;

	// Result queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Parser modes
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_WAIT_BT      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SCAN         = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EXPECT_PAREN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CAPTURE      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SKIP_TJ      = 3'd4;

	// Character codes
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_J     = 8'h6a;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_string;
		logic [7:0] string_index;
	} out_item_t;

	// Up to two results produced by one parsed byte
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
	} res_push_t;

endpackage

>>> src/ptse_parser.sv
// Input register and byte parser of the PDF text string extractor.
// Parses one registered byte per cycle while the result queue has room, and pushes up to two results.
// Depends on ptse_pkg.
module ptse_parser import ptse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	input  logic      room,
	output res_push_t push
);

	logic                valid_s1;
	in_item_t            item_s1;
	logic                fire;

	logic [MODE_W-1:0]   mode_q;
	logic [7:0]          prev_q;
	logic                tp_q;
	logic                tbe_q;
	logic [7:0]          depth_q;
	logic                esc_q;
	logic                sup_q;
	logic [TLEN_W-1:0]   tlen_q;
	logic [SCNT_W-1:0]   scnt_q;

	logic [MODE_W-1:0]   mode_n;
	logic                tp_n;
	logic                tbe_n;
	logic [7:0]          depth_n;
	logic                esc_n;
	logic                sup_n;
	logic [TLEN_W-1:0]   tlen_n;
	logic [SCNT_W-1:0]   scnt_n;
	logic [7:0]          prev_v;

	logic [1:0]          nchar;
	logic [7:0]          c0;
	logic [7:0]          c1;
	logic                eos;
	logic [7:0]          eos_index;
	logic                do_scan;
	res_push_t           push_n;

	// Hold the byte while the result queue lacks room for two results
	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Work out next state and results for the registered byte
	always_comb begin
		mode_n  = mode_q;
		prev_v  = prev_q;
		tp_n    = tp_q;
		tbe_n   = tbe_q;
		depth_n = depth_q;
		esc_n   = esc_q;
		sup_n   = sup_q;
		tlen_n  = tlen_q;
		scnt_n  = scnt_q;
		nchar   = 2'd0;
		c0      = 8'd0;
		c1      = 8'd0;
		eos     = 1'b0;
		do_scan = 1'b0;
		push_n  = '0;

		// New stream: clear everything, then parse this byte
		if (item_s1.stream_start) begin
			mode_n  = MODE_WAIT_BT;
			prev_v  = 8'd0;
			tp_n    = 1'b0;
			tbe_n   = 1'b0;
			depth_n = 8'd0;
			esc_n   = 1'b0;
			sup_n   = 1'b0;
			tlen_n  = '0;
			scnt_n  = '0;
		end

		eos_index = scnt_n[7:0];

		unique case (mode_n)
			MODE_WAIT_BT: begin
				if (prev_v == CH_B && item_s1.data_byte == CH_T) begin
					mode_n = MODE_SCAN;
				end
			end
			MODE_SCAN: begin
				do_scan = 1'b1;
			end
			MODE_EXPECT_PAREN: begin
				if (item_s1.data_byte == CH_LPAR) begin
					mode_n  = MODE_CAPTURE;
					depth_n = 8'd1;
					esc_n   = 1'b0;
					tlen_n  = '0;
					sup_n   = (scnt_n >= SCNT_W'(MAX_STRINGS));
				end else begin
					mode_n  = MODE_SCAN;
					do_scan = 1'b1;
				end
			end
			MODE_CAPTURE: begin
				if (esc_n) begin
					esc_n = 1'b0;
					if (item_s1.data_byte == CH_CR) begin
						nchar = 2'd1;
						c0    = CH_SPACE;
					end else begin
						nchar = 2'd2;
						c0    = CH_BSL;
						c1    = item_s1.data_byte;
					end
				end else begin
					if (tlen_n == '0 && item_s1.data_byte == CH_DASH) begin
						sup_n = 1'b1;
					end
					if (item_s1.data_byte == CH_BSL) begin
						esc_n = 1'b1;
					end else if (item_s1.data_byte == CH_LPAR) begin
						if (depth_n < DEPTH_MAX) begin
							depth_n = depth_n + 8'd1;
						end
						nchar = 2'd1;
						c0    = item_s1.data_byte;
					end else if (item_s1.data_byte == CH_RPAR) begin
						if (depth_n != 8'd0) begin
							depth_n = depth_n - 8'd1;
						end
						if (depth_n == 8'd0) begin
							if (!sup_n) begin
								eos = 1'b1;
								if (scnt_n < SCNT_W'(MAX_STRINGS)) begin
									scnt_n = scnt_n + SCNT_W'(1);
								end
							end
							mode_n = MODE_SKIP_TJ;
						end else begin
							nchar = 2'd1;
							c0    = item_s1.data_byte;
						end
					end else begin
						nchar = 2'd1;
						c0    = item_s1.data_byte;
					end
				end
			end
			MODE_SKIP_TJ: begin
				if (prev_v == CH_T && item_s1.data_byte == CH_J) begin
					mode_n = MODE_SCAN;
					tp_n   = 1'b0;
				end
			end
			default: begin
				mode_n = MODE_WAIT_BT;
			end
		endcase

		// Look for T followed by m or d, not right after B or E
		if (do_scan) begin
			if (tp_n && !tbe_n &&
				(item_s1.data_byte == CH_M || item_s1.data_byte == CH_D)) begin
				tp_n   = 1'b0;
				mode_n = MODE_EXPECT_PAREN;
			end else if (item_s1.data_byte == CH_T) begin
				tp_n  = 1'b1;
				tbe_n = (prev_v == CH_B || prev_v == CH_E);
			end else begin
				tp_n = 1'b0;
			end
		end

		// Emit characters up to the length limit
		if (nchar != 2'd0) begin
			if (!sup_n && tlen_n < TLEN_W'(MAX_TEXT)) begin
				push_n.r0  = '{text_byte: c0, end_of_string: 1'b0,
					string_index: scnt_n[7:0]};
				push_n.cnt = 2'd1;
			end
			if (tlen_n < TLEN_W'(MAX_TEXT)) begin
				tlen_n = tlen_n + TLEN_W'(1);
			end
		end
		if (nchar == 2'd2) begin
			if (!sup_n && tlen_n < TLEN_W'(MAX_TEXT)) begin
				if (push_n.cnt == 2'd0) begin
					push_n.r0 = '{text_byte: c1, end_of_string: 1'b0,
						string_index: scnt_n[7:0]};
				end else begin
					push_n.r1 = '{text_byte: c1, end_of_string: 1'b0,
						string_index: scnt_n[7:0]};
				end
				push_n.cnt = push_n.cnt + 2'd1;
			end
			if (tlen_n < TLEN_W'(MAX_TEXT)) begin
				tlen_n = tlen_n + TLEN_W'(1);
			end
		end
		if (eos) begin
			push_n.r0  = '{text_byte: 8'd0, end_of_string: 1'b1,
				string_index: eos_index};
			push_n.cnt = 2'd1;
		end

		if (!fire) begin
			push_n.cnt = 2'd0;
		end
	end

	assign push = push_n;

	// Advance parser state on each parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT_BT;
			prev_q  <= 8'd0;
			tp_q    <= 1'b0;
			tbe_q   <= 1'b0;
			depth_q <= 8'd0;
			esc_q   <= 1'b0;
			sup_q   <= 1'b0;
			tlen_q  <= '0;
			scnt_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			prev_q  <= item_s1.data_byte;
			tp_q    <= tp_n;
			tbe_q   <= tbe_n;
			depth_q <= depth_n;
			esc_q   <= esc_n;
			sup_q   <= sup_n;
			tlen_q  <= tlen_n;
			scnt_q  <= scnt_n;
		end
	end

endmodule

>>> src/ptse_out_fifo.sv
// Result queue of the PDF text string extractor.
// Takes up to two results a cycle, presents one a cycle on the output unless result_stall holds it.
// Depends on ptse_pkg.
module ptse_out_fifo import ptse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      room,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	out_item_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign result_valid = (count_q != '0);
	assign result       = mem[rd_q];
	assign pop          = result_valid && !result_stall;
	assign room         = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	// Write one or two results
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.cnt);
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
		end
	end

endmodule

>>> src/pdf_text_string_extractor_unit.sv
// Path: an accepted byte is registered in the parser input stage, then its results are written into the
// result queue and presented from there; a second result from the same byte follows the first.
// Throughput: one byte per cycle while the result queue has room; a byte yields zero to two results and the
// output moves one result per cycle unless result_stall is high, set by the four-entry result queue.
// Reset: arst_n clears the parser state and empties the input stage and queue.
// Top level of the PDF text string extractor; depends on ptse_pkg, ptse_parser, ptse_out_fifo.
module pdf_text_string_extractor_unit import ptse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	res_push_t push;
	logic      room;

	// Parse registered bytes
	ptse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.room       (room),
		.push       (push)
	);

	// Queue results toward the output
	ptse_out_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> src/ptse_checker.sv
// Port-level checker for the PDF text string extractor, bound to the top level.
// Depends on ptse_pkg.
module ptse_checker import ptse_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// A stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// End markers carry no character
	a_eos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_string |-> result.text_byte == 8'd0)
		else $error("end marker with nonzero byte");

	// Input backpressure only with results queued
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with empty output");

	// A result appearing on an empty output traces back to an accepted byte, via the input register and the queue
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without matching input transaction");

endmodule

bind pdf_text_string_extractor_unit ptse_checker u_ptse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
